/* rtl/e2r_pkg.sv */
// ---------------------------------------------------------------------------
// e2r_pkg
// Shared constants, operand codes and arithmetic helpers for the Euler angle
// to rotation matrix pipeline.
// ---------------------------------------------------------------------------
package e2r_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF  = 16;
   localparam int FIELD_W        = 16;

   localparam int SIN_LAT = 14;
   localparam int MAT_LAT = 6;
   localparam int LAT     = SIN_LAT + MAT_LAT;

   localparam logic signed [32:0] P_A1 = 33'sd1686629713;
   localparam logic signed [32:0] P_A3 = 33'sd693598668;
   localparam logic signed [32:0] P_A5 = 33'sd85569306;
   localparam logic signed [32:0] P_A7 = 33'sd5026995;
   localparam logic signed [32:0] P_A9 = 33'sd172272;

   typedef logic [1:0] order_type;
   localparam order_type ORD_XYZ = 2'd0;
   localparam order_type ORD_ZXY = 2'd1;
   localparam order_type ORD_ZYX = 2'd2;

   typedef logic [2:0] opd_type;
   localparam opd_type OPD_CX   = 3'd0;
   localparam opd_type OPD_SX   = 3'd1;
   localparam opd_type OPD_CY   = 3'd2;
   localparam opd_type OPD_SY   = 3'd3;
   localparam opd_type OPD_CZ   = 3'd4;
   localparam opd_type OPD_SZ   = 3'd5;
   localparam opd_type OPD_ONE  = 3'd6;
   localparam opd_type OPD_ZERO = 3'd7;

   typedef struct packed {
      opd_type a;
      opd_type b;
      logic    neg1;
      opd_type c;
      opd_type d;
      opd_type e;
      logic    neg2;
   } term_type;

   function automatic logic signed [65:0] rnd_half_away(input logic signed [65:0] v,
                                                        input logic [5:0] sh);
      logic [65:0] mag;
      logic [65:0] res;
      mag = v[65] ? 66'(-v) : 66'(v);
      res = (mag + (66'd1 << (sh - 6'd1))) >> sh;
      return v[65] ? -$signed(res) : $signed(res);
   endfunction

   function automatic logic signed [32:0] poly_coef(input logic [1:0] k);
      logic signed [32:0] c;
      unique case (k)
         2'd0: c = -P_A7;
         2'd1: c = P_A5;
         2'd2: c = -P_A3;
         2'd3: c = P_A1;
      endcase
      return c;
   endfunction

   function automatic term_type mk(input opd_type a, input opd_type b, input logic n1,
                                   input opd_type c, input opd_type d, input opd_type e,
                                   input logic n2);
      term_type t;
      t.a = a; t.b = b; t.neg1 = n1; t.c = c; t.d = d; t.e = e; t.neg2 = n2;
      return t;
   endfunction

   function automatic term_type entry_sel(input order_type ord, input logic [3:0] idx);
      term_type t;
      t = mk(OPD_ZERO, OPD_ZERO, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
      priority case (ord)
         ORD_ZXY: begin
            unique case (idx)
               4'd0: t = mk(OPD_CY, OPD_CZ, 1'b0, OPD_SX, OPD_SY, OPD_SZ, 1'b1);
               4'd1: t = mk(OPD_CX, OPD_SZ, 1'b1, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd2: t = mk(OPD_CZ, OPD_SY, 1'b0, OPD_CY, OPD_SX, OPD_SZ, 1'b0);
               4'd3: t = mk(OPD_CY, OPD_SZ, 1'b0, OPD_CZ, OPD_SX, OPD_SY, 1'b0);
               4'd4: t = mk(OPD_CX, OPD_CZ, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd5: t = mk(OPD_SY, OPD_SZ, 1'b0, OPD_CY, OPD_CZ, OPD_SX, 1'b1);
               4'd6: t = mk(OPD_CX, OPD_SY, 1'b1, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd7: t = mk(OPD_SX, OPD_ONE, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               default: t = mk(OPD_CX, OPD_CY, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
            endcase
         end
         ORD_ZYX: begin
            unique case (idx)
               4'd0: t = mk(OPD_CZ, OPD_CY, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd1: t = mk(OPD_SZ, OPD_CX, 1'b1, OPD_CZ, OPD_SY, OPD_SX, 1'b0);
               4'd2: t = mk(OPD_SZ, OPD_SX, 1'b0, OPD_CZ, OPD_SY, OPD_CX, 1'b0);
               4'd3: t = mk(OPD_SZ, OPD_CY, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd4: t = mk(OPD_CZ, OPD_CX, 1'b0, OPD_SZ, OPD_SY, OPD_SX, 1'b0);
               4'd5: t = mk(OPD_CZ, OPD_SX, 1'b1, OPD_SZ, OPD_SY, OPD_CX, 1'b0);
               4'd6: t = mk(OPD_SY, OPD_ONE, 1'b1, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd7: t = mk(OPD_CY, OPD_SX, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               default: t = mk(OPD_CY, OPD_CX, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
            endcase
         end
         default: begin
            unique case (idx)
               4'd0: t = mk(OPD_CY, OPD_CZ, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd1: t = mk(OPD_CY, OPD_SZ, 1'b1, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd2: t = mk(OPD_SY, OPD_ONE, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd3: t = mk(OPD_CX, OPD_SZ, 1'b0, OPD_SX, OPD_SY, OPD_CZ, 1'b0);
               4'd4: t = mk(OPD_CX, OPD_CZ, 1'b0, OPD_SX, OPD_SY, OPD_SZ, 1'b1);
               4'd5: t = mk(OPD_CY, OPD_SX, 1'b1, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
               4'd6: t = mk(OPD_SX, OPD_SZ, 1'b0, OPD_CX, OPD_SY, OPD_CZ, 1'b1);
               4'd7: t = mk(OPD_CZ, OPD_SX, 1'b0, OPD_CX, OPD_SY, OPD_SZ, 1'b0);
               default: t = mk(OPD_CX, OPD_CY, 1'b0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
            endcase
         end
      endcase
      return t;
   endfunction

endpackage

/* rtl/e2r_sine.sv */
// ---------------------------------------------------------------------------
// e2r_sine
// Pipelined fixed-point sine of a binary angle: quarter-wave fold, then an
// odd polynomial in Q30 with one multiply per stage.
// ---------------------------------------------------------------------------
module e2r_sine #(
   parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
   parameter int COEF_BITS  = e2r_pkg::COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic [ANGLE_BITS-1:0]       angle,
   output logic signed [COEF_BITS-1:0] value
);
   import e2r_pkg::*;

   localparam int FRAC  = COEF_BITS - 2;
   localparam int USH   = 30 - (ANGLE_BITS - 2);
   localparam int RW    = ANGLE_BITS - 1;
   localparam logic [RW-1:0] QTR = {1'b1, {(ANGLE_BITS-2){1'b0}}};
   localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC;

   logic [1:0]         quad;
   logic [RW-1:0]      rm;
   logic [30:0]        u_in;

   logic [30:0]        u_ff    [1:11];
   logic               neg_ff  [1:13];
   logic [61:0]        usq_ff;
   logic [30:0]        usqr_ff [3:9];
   logic signed [65:0] m_ff    [4];
   logic signed [32:0] p_ff    [4];
   logic signed [32:0] psrc    [4];
   logic signed [65:0] f_ff;
   logic signed [32:0] q_ff;
   logic signed [65:0] s_in;
   logic signed [65:0] c_in;
   logic signed [COEF_BITS-1:0] value_ff;

   assign quad = angle[ANGLE_BITS-1 -: 2];
   assign rm   = quad[0] ? QTR - RW'(angle[ANGLE_BITS-3:0]) : RW'(angle[ANGLE_BITS-3:0]);
   assign u_in = 31'(rm) << USH;

   always_comb begin
      psrc[0] = P_A9;
      for (int k = 1; k < 4; k++) begin
         psrc[k] = p_ff[k-1];
      end
   end

   always_comb begin
      s_in = rnd_half_away(66'(q_ff), 6'(30 - FRAC));
      c_in = s_in;
      if (s_in < 0) begin
         c_in = '0;
      end
      if (s_in > ONE) begin
         c_in = ONE;
      end
   end

   always_ff @(posedge clock) begin
      u_ff[1]   <= u_in;
      neg_ff[1] <= quad[1];
      for (int i = 2; i <= 11; i++) begin
         u_ff[i] <= u_ff[i-1];
      end
      for (int i = 2; i <= 13; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end
      usq_ff     <= 62'(u_ff[1]) * 62'(u_ff[1]);
      usqr_ff[3] <= 31'(rnd_half_away($signed({4'b0, usq_ff}), 6'd30));
      for (int i = 4; i <= 9; i++) begin
         usqr_ff[i] <= usqr_ff[i-1];
      end
      for (int k = 0; k < 4; k++) begin
         m_ff[k] <= 66'(psrc[k]) * 66'($signed({1'b0, usqr_ff[3+2*k]}));
         p_ff[k] <= 33'(rnd_half_away(m_ff[k], 6'd30)) + poly_coef(2'(k));
      end
      f_ff     <= 66'(p_ff[3]) * 66'($signed({1'b0, u_ff[11]}));
      q_ff     <= 33'(rnd_half_away(f_ff, 6'd30));
      value_ff <= neg_ff[13] ? COEF_BITS'(-c_in) : COEF_BITS'(c_in);
   end

   assign value = value_ff;

endmodule

/* rtl/e2r_matrix.sv */
// ---------------------------------------------------------------------------
// e2r_matrix
// Six-stage matrix builder: operand select, products, rounding, triple
// product, sum, then round and saturate each of the nine entries.
// ---------------------------------------------------------------------------
module e2r_matrix #(
   parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  e2r_pkg::order_type            order,
   input  logic signed [COEF_BITS-1:0]   sin_val [3],
   input  logic signed [COEF_BITS-1:0]   cos_val [3],
   output logic [e2r_pkg::FIELD_W-1:0]   entry   [9]
);
   import e2r_pkg::*;

   localparam int FRAC = COEF_BITS - 2;
   localparam int PW   = 2 * COEF_BITS;
   localparam int SW   = PW + 1;
   localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC;
   localparam logic signed [COEF_BITS-1:0] ONE_C = COEF_BITS'(ONE);

   logic signed [COEF_BITS-1:0] cx, sx, cy, sy, cz, sz;
   logic [1:0] xi, yi, zi;

   logic signed [COEF_BITS-1:0] a_ff [9], b_ff [9], c_ff [9], d_ff [9], e_ff [9];
   logic                        n1_ff [9], n2_ff [9];
   logic signed [PW-1:0]        p1_ff [9], p2_ff [9];
   logic signed [COEF_BITS-1:0] e2_ff [9];
   logic                        n1b_ff [9], n2b_ff [9];
   logic signed [PW-1:0]        p1c_ff [9];
   logic signed [COEF_BITS-1:0] r2_ff [9], e3_ff [9];
   logic                        n1c_ff [9], n2c_ff [9];
   logic signed [PW-1:0]        p1d_ff [9], p3_ff [9];
   logic                        n1d_ff [9], n2d_ff [9];
   logic signed [SW-1:0]        sum_ff [9];
   logic [FIELD_W-1:0]          out_ff [9];

   function automatic logic signed [COEF_BITS-1:0] pick(input opd_type code,
         input logic signed [COEF_BITS-1:0] vcx, input logic signed [COEF_BITS-1:0] vsx,
         input logic signed [COEF_BITS-1:0] vcy, input logic signed [COEF_BITS-1:0] vsy,
         input logic signed [COEF_BITS-1:0] vcz, input logic signed [COEF_BITS-1:0] vsz);
      logic signed [COEF_BITS-1:0] r;
      unique case (code)
         OPD_CX:  r = vcx;
         OPD_SX:  r = vsx;
         OPD_CY:  r = vcy;
         OPD_SY:  r = vsy;
         OPD_CZ:  r = vcz;
         OPD_SZ:  r = vsz;
         OPD_ONE: r = ONE_C;
         default: r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      priority case (order)
         ORD_ZXY: begin xi = 2'd1; yi = 2'd2; zi = 2'd0; end
         ORD_ZYX: begin xi = 2'd2; yi = 2'd1; zi = 2'd0; end
         default: begin xi = 2'd0; yi = 2'd1; zi = 2'd2; end
      endcase
      cx = cos_val[xi]; sx = sin_val[xi];
      cy = cos_val[yi]; sy = sin_val[yi];
      cz = cos_val[zi]; sz = sin_val[zi];
   end

   for (genvar i = 0; i < 9; i++) begin : g_ent
      term_type           sel;
      logic signed [SW-1:0] t1, t3;
      logic signed [65:0] v_rnd;
      logic signed [65:0] v_sat;

      assign sel = entry_sel(order, 4'(i));
      assign t1  = n1d_ff[i] ? -SW'(p1d_ff[i]) : SW'(p1d_ff[i]);
      assign t3  = n2d_ff[i] ? -SW'(p3_ff[i]) : SW'(p3_ff[i]);

      always_comb begin
         v_rnd = rnd_half_away(66'(sum_ff[i]), 6'(FRAC));
         v_sat = v_rnd;
         if (v_rnd > ONE) begin
            v_sat = ONE;
         end
         if (v_rnd < -ONE) begin
            v_sat = -ONE;
         end
      end

      always_ff @(posedge clock) begin
         a_ff[i]   <= pick(sel.a, cx, sx, cy, sy, cz, sz);
         b_ff[i]   <= pick(sel.b, cx, sx, cy, sy, cz, sz);
         c_ff[i]   <= pick(sel.c, cx, sx, cy, sy, cz, sz);
         d_ff[i]   <= pick(sel.d, cx, sx, cy, sy, cz, sz);
         e_ff[i]   <= pick(sel.e, cx, sx, cy, sy, cz, sz);
         n1_ff[i]  <= sel.neg1;
         n2_ff[i]  <= sel.neg2;

         p1_ff[i]  <= PW'(a_ff[i]) * PW'(b_ff[i]);
         p2_ff[i]  <= PW'(c_ff[i]) * PW'(d_ff[i]);
         e2_ff[i]  <= e_ff[i];
         n1b_ff[i] <= n1_ff[i];
         n2b_ff[i] <= n2_ff[i];

         p1c_ff[i] <= p1_ff[i];
         r2_ff[i]  <= COEF_BITS'(rnd_half_away(66'(p2_ff[i]), 6'(FRAC)));
         e3_ff[i]  <= e2_ff[i];
         n1c_ff[i] <= n1b_ff[i];
         n2c_ff[i] <= n2b_ff[i];

         p1d_ff[i] <= p1c_ff[i];
         p3_ff[i]  <= PW'(r2_ff[i]) * PW'(e3_ff[i]);
         n1d_ff[i] <= n1c_ff[i];
         n2d_ff[i] <= n2c_ff[i];

         sum_ff[i] <= t1 + t3;
         out_ff[i] <= v_sat[FIELD_W-1:0];
      end

      assign entry[i] = out_ff[i];
   end

endmodule

/* rtl/euler_to_rotation_matrix.sv */
// ---------------------------------------------------------------------------
// euler_to_rotation_matrix
// Results follow start through the 14-stage sine and the 6-stage matrix to rsp_valid.
// Throughput: one item per cycle; busy is high only during reset.
// Each result shows on the rsp_ ports for one cycle; the receiver cannot stall.
// Reset clears the valid line and sets the rotation order to XYZ.
// ---------------------------------------------------------------------------
module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
   parameter int COEF_BITS  = e2r_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [e2r_pkg::FIELD_W-1:0]  req_angle_first,
   input  logic signed [e2r_pkg::FIELD_W-1:0]  req_angle_second,
   input  logic signed [e2r_pkg::FIELD_W-1:0]  req_angle_third,
   output logic                                rsp_valid,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m00,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m01,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m02,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m10,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m11,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m12,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m20,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m21,
   output logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m22,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  e2r_pkg::order_type                  csr_rotation_order
);
   import e2r_pkg::*;

   localparam logic [ANGLE_BITS-1:0] QTR = {2'b01, {(ANGLE_BITS-2){1'b0}}};

   logic [ANGLE_BITS-1:0]       ang [3];
   logic signed [COEF_BITS-1:0] sin_val [3];
   logic signed [COEF_BITS-1:0] cos_val [3];
   logic [FIELD_W-1:0]          entry [9];

   order_type order_ff;
   order_type ord_ff   [SIN_LAT];
   logic      valid_ff [LAT];
   logic      accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign ang[0] = ANGLE_BITS'({{ANGLE_BITS{req_angle_first[FIELD_W-1]}},  req_angle_first});
   assign ang[1] = ANGLE_BITS'({{ANGLE_BITS{req_angle_second[FIELD_W-1]}}, req_angle_second});
   assign ang[2] = ANGLE_BITS'({{ANGLE_BITS{req_angle_third[FIELD_W-1]}},  req_angle_third});

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORD_XYZ;
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            order_ff <= csr_rotation_order;
         end
         valid_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ord_ff[0] <= order_ff;
      for (int i = 1; i < SIN_LAT; i++) begin
         ord_ff[i] <= ord_ff[i-1];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_trig
      e2r_sine #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_sin (
         .clock (clock),
         .angle (ang[k]),
         .value (sin_val[k])
      );
      e2r_sine #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cos (
         .clock (clock),
         .angle (ang[k] + QTR),
         .value (cos_val[k])
      );
   end

   e2r_matrix #(.COEF_BITS(COEF_BITS)) u_matrix (
      .clock   (clock),
      .order   (ord_ff[SIN_LAT-1]),
      .sin_val (sin_val),
      .cos_val (cos_val),
      .entry   (entry)
   );

   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_m00   = entry[0];
   assign rsp_m01   = entry[1];
   assign rsp_m02   = entry[2];
   assign rsp_m10   = entry[3];
   assign rsp_m11   = entry[4];
   assign rsp_m12   = entry[5];
   assign rsp_m20   = entry[6];
   assign rsp_m21   = entry[7];
   assign rsp_m22   = entry[8];

endmodule

/* rtl/e2r_check.sv */
// ---------------------------------------------------------------------------
// e2r_check
// Port-level checks on latency, result range and channel readiness.
// ---------------------------------------------------------------------------
module e2r_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m00,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m01,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m02,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m10,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m11,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m12,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m20,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m21,
   input logic signed [e2r_pkg::FIELD_W-1:0]  rsp_m22,
   input logic                                csr_valid,
   input logic                                csr_ready
);
   import e2r_pkg::*;

   localparam logic signed [FIELD_W-1:0] LIM = 16'sd16384;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("item result missing");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without item");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_m00 <= LIM && rsp_m00 >= -LIM && rsp_m01 <= LIM && rsp_m01 >= -LIM
                 && rsp_m02 <= LIM && rsp_m02 >= -LIM && rsp_m10 <= LIM && rsp_m10 >= -LIM
                 && rsp_m11 <= LIM && rsp_m11 >= -LIM && rsp_m12 <= LIM && rsp_m12 >= -LIM
                 && rsp_m20 <= LIM && rsp_m20 >= -LIM && rsp_m21 <= LIM && rsp_m21 >= -LIM
                 && rsp_m22 <= LIM && rsp_m22 >= -LIM)
      else $error("entry out of range");

   a_ready: assert property (@(posedge clock)
      !reset |-> !busy && (csr_ready || !csr_valid))
      else $error("channel not ready");

endmodule

bind euler_to_rotation_matrix e2r_check u_e2r_check (.*);
